// File: src/agdd_pkg.sv
// Shared constants and types for the allocation graph deadlock detector.
`default_nettype none
package agdd_pkg;

  localparam int NUM_PROCESSES_DEF = 16;
  localparam int NUM_RESOURCES_DEF = 4;

  localparam int PROC_IDX_W = 4;
  localparam int RES_IDX_W  = 2;
  localparam int STATUS_W   = 2;

  localparam logic [STATUS_W-1:0] STATUS_REQUEST = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_HOLD    = 2'd2;

  typedef struct packed {
    logic load;    // write the cell and mark every node live
    logic step;    // run one parallel sink-removal pass
    logic report;  // present the verdict for one cycle
  } agdd_cmd_t;

endpackage
`default_nettype wire

// File: src/agdd_ctrl.sv
// Controller state machine: sequences cell write, removal passes and result.
`default_nettype none
module agdd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              pass_done,
  output logic                   busy,
  output agdd_pkg::agdd_cmd_t    cmd
);
  import agdd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PASS = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.report = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        cmd.step = 1'b1;
        if (pass_done) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// File: src/agdd_datapath.sv
// Datapath: relation cell matrix, live node mask and the sink-removal pass logic.
`default_nettype none
module agdd_datapath #(
  parameter int NUM_PROCESSES = agdd_pkg::NUM_PROCESSES_DEF,
  parameter int NUM_RESOURCES = agdd_pkg::NUM_RESOURCES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire agdd_pkg::agdd_cmd_t             cmd,
  input  wire logic [agdd_pkg::PROC_IDX_W-1:0] in_process_index,
  input  wire logic [agdd_pkg::RES_IDX_W-1:0]  in_resource_index,
  input  wire logic [agdd_pkg::STATUS_W-1:0]   in_new_status,
  output logic                                 pass_done,
  output logic                                 out_valid,
  output logic                                 out_deadlock
);
  import agdd_pkg::*;

  localparam int NODE_COUNT = NUM_PROCESSES + NUM_RESOURCES;

  logic [STATUS_W-1:0]   cell_r [NUM_RESOURCES][NUM_PROCESSES];
  logic [NODE_COUNT-1:0] live_r;
  logic [NODE_COUNT-1:0] live_nxt;
  logic                  out_valid_r;
  logic                  out_deadlock_r;
  logic                  status_ok;

  // Code three leaves the cell untouched; out-of-range indexes match no cell.
  assign status_ok = (in_new_status <= STATUS_HOLD);

  // One pass: a node survives only if it still has an edge to a live node.
  always_comb begin
    logic succ;
    for (int p = 0; p < NUM_PROCESSES; p++) begin
      succ = 1'b0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        succ = succ | ((cell_r[r][p] == STATUS_REQUEST) && live_r[NUM_PROCESSES + r]);
      end
      live_nxt[p] = live_r[p] & succ;
    end
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      succ = 1'b0;
      for (int p = 0; p < NUM_PROCESSES; p++) begin
        succ = succ | ((cell_r[r][p] == STATUS_HOLD) && live_r[p]);
      end
      live_nxt[NUM_PROCESSES + r] = live_r[NUM_PROCESSES + r] & succ;
    end
  end

  assign pass_done = (live_nxt == live_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        for (int p = 0; p < NUM_PROCESSES; p++) begin
          cell_r[r][p] <= '0;
        end
      end
      live_r <= '0;
    end else if (cmd.load) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        for (int p = 0; p < NUM_PROCESSES; p++) begin
          if (status_ok && (int'(in_process_index) == p) &&
              (int'(in_resource_index) == r)) begin
            cell_r[r][p] <= in_new_status;
          end
        end
      end
      live_r <= '1;
    end else if (cmd.step) begin
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.report;
    end
  end

  // At the fixed point any node left lies on or leads into a cycle.
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_deadlock_r <= |live_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_deadlock = out_deadlock_r;

endmodule
`default_nettype wire

// File: src/allocation_graph_deadlock_detector_top.sv
// Top level of the allocation graph deadlock detector.
// Each item written with start while busy is low updates one relation cell and then
// runs sink-removal passes over all nodes at once, one pass per clock, until the live
// set stops changing. The passes last until the longest chain of nodes that drain one
// after another has drained, plus the pass that finds nothing left to remove. Such a
// chain alternates processes and resources, so it has at most 2 * NUM_RESOURCES + 1
// nodes. busy is high while the passes run, and out_valid with out_deadlock follows
// in the next cycle, for that one cycle only, since the receiver cannot hold the
// result. A new item may be started in the result's cycle.
`default_nettype none
module allocation_graph_deadlock_detector_top #(
  parameter int NUM_PROCESSES = agdd_pkg::NUM_PROCESSES_DEF,
  parameter int NUM_RESOURCES = agdd_pkg::NUM_RESOURCES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [agdd_pkg::PROC_IDX_W-1:0] in_process_index,
  input  wire logic [agdd_pkg::RES_IDX_W-1:0]  in_resource_index,
  input  wire logic [agdd_pkg::STATUS_W-1:0]   in_new_status,
  output logic                                 out_valid,
  output logic                                 out_deadlock
);
  import agdd_pkg::*;

  agdd_cmd_t cmd;
  logic      pass_done;

  agdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .pass_done (pass_done),
    .busy      (busy),
    .cmd       (cmd)
  );

  agdd_datapath #(
    .NUM_PROCESSES (NUM_PROCESSES),
    .NUM_RESOURCES (NUM_RESOURCES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_process_index  (in_process_index),
    .in_resource_index (in_resource_index),
    .in_new_status     (in_new_status),
    .pass_done         (pass_done),
    .out_valid         (out_valid),
    .out_deadlock      (out_deadlock)
  );

endmodule
`default_nettype wire

// File: src/agdd_checker.sv
// Port-level checker for the deadlock detector and its bind to the top level.
`default_nettype none
module agdd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // A result never comes in the cycle right after acceptance.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result appeared too early");

  // Results are shown only once the block has gone idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Each item gives a single one-cycle result.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

endmodule

bind allocation_graph_deadlock_detector_top agdd_checker u_agdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire
